/* hw/rtl/otds_pkg.sv */
// otds_pkg: shared types, constants and helpers for the over-temperature supervisor
// no dependencies; imported by overtemp_derate_supervisor_top and tb

package otds_pkg;

  // field and register widths
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned THRESH_W   = 13;
  localparam int unsigned HOLD_W     = 32;
  localparam int unsigned SCAN_W     = 8;
  localparam int unsigned CONFIRM_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STATE_W    = 2;

  // width of the scaled compare: adc*6 against threshold*5
  localparam int unsigned CMP_W = 16;

  // mv = adc*12/10, so mv < thr exactly when adc*6 < thr*5
  localparam logic [CMP_W-1:0] ADC_SCALE    = CMP_W'(6);
  localparam logic [CMP_W-1:0] THRESH_SCALE = CMP_W'(5);

  // register reset values
  localparam logic [THRESH_W-1:0]  THRESH_RESET  = THRESH_W'(1000);
  localparam logic [HOLD_W-1:0]    HOLD_RESET    = HOLD_W'(30000);
  localparam logic [SCAN_W-1:0]    SCAN_RESET    = SCAN_W'(100);
  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = CONFIRM_W'(10);

  localparam logic [CONFIRM_W-1:0] CONFIRM_MAX = '1;
  localparam logic [HOLD_W-1:0]    HOLD_MAX    = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOT_THRESHOLD = 2'd0,
    CFG_HOLD_TICKS    = 2'd1,
    CFG_SCAN_DIVIDER  = 2'd2,
    CFG_CONFIRM_COUNT = 2'd3
  } cfg_idx_t;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // supervisor state codes
  typedef enum logic [STATE_W-1:0] {
    ST_NORMAL  = 2'd0,
    ST_HOT     = 2'd1,
    ST_LATCHED = 2'd2
  } temp_state_t;

  // extend a run of low readings, saturating, or restart it on a high one
  function automatic logic [CONFIRM_W-1:0] next_confirm(
    input logic [CONFIRM_W-1:0] c,
    input logic                 low
  );
    logic [CONFIRM_W-1:0] r;
    if (!low) begin
      r = '0;
    end else if (c == CONFIRM_MAX) begin
      r = CONFIRM_MAX;
    end else begin
      r = c + CONFIRM_W'(1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/overtemp_derate_supervisor_top.sv */
// overtemp_derate_supervisor_top: over-temperature supervisor with hold timer and latch
// depends on otds_pkg
//
// a result word is registered and appears in the cycle after its input word is accepted
// throughput: one word per cycle when not stalled, one state update register stage
// reset: synchronous rst restores register defaults, normal state, counters cleared

module overtemp_derate_supervisor_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [otds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [otds_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [otds_pkg::ADC_W-1:0]          temp_adc,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [otds_pkg::STATE_W-1:0]        temp_state,
  output logic                                timer_running
);

  import otds_pkg::*;

  // configuration registers
  logic [THRESH_W-1:0]  hot_threshold_mv;
  logic [HOLD_W-1:0]    hold_ticks;
  logic [SCAN_W-1:0]    scan_divider;
  logic [CONFIRM_W-1:0] confirm_count;

  // supervisor state
  temp_state_t          state_code, state_code_next;
  logic [SCAN_W-1:0]    prescale_count, prescale_count_next;
  logic [CONFIRM_W-1:0] normal_confirm, normal_confirm_next;
  logic [CONFIRM_W-1:0] hot_confirm, hot_confirm_next;
  logic                 hold_open, hold_open_next;
  logic [HOLD_W-1:0]    hold_elapsed, hold_elapsed_next;

  logic                 in_fire;
  logic                 low;
  logic [SCAN_W-1:0]    prescale_inc;
  logic [CONFIRM_W-1:0] nc, hc;
  logic [HOLD_W-1:0]    elapsed_eval;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // low voltage test without a divider
  assign low = ((CMP_W'(temp_adc) * ADC_SCALE) < (CMP_W'(hot_threshold_mv) * THRESH_SCALE));

  assign prescale_inc = prescale_count + SCAN_W'(1);

  // next state for one accepted word
  always_comb begin
    state_code_next     = state_code;
    prescale_count_next = prescale_count;
    normal_confirm_next = normal_confirm;
    hot_confirm_next    = hot_confirm;
    hold_open_next      = hold_open;
    hold_elapsed_next   = hold_elapsed;
    nc                  = next_confirm(normal_confirm, low);
    hc                  = next_confirm(hot_confirm, low);
    elapsed_eval        = hold_open ? hold_elapsed : '0;

    if (kind == KIND_TICK) begin
      // tick advances the hold timer only while it runs
      if (hold_open && hold_elapsed != HOLD_MAX) begin
        hold_elapsed_next = hold_elapsed + HOLD_W'(1);
      end
    end else if (state_code != ST_LATCHED) begin
      if (prescale_inc < scan_divider) begin
        prescale_count_next = prescale_inc;
      end else begin
        prescale_count_next = '0;
        // evaluated sample
        case (state_code)
          ST_NORMAL: begin
            normal_confirm_next = nc;
            if (nc >= confirm_count) begin
              normal_confirm_next = '0;
              state_code_next     = ST_HOT;
            end
          end
          ST_HOT: begin
            hold_open_next    = 1'b1;
            hold_elapsed_next = elapsed_eval;
            if (elapsed_eval >= hold_ticks) begin
              hot_confirm_next = hc;
              if (hc >= confirm_count) begin
                hot_confirm_next  = '0;
                state_code_next   = ST_LATCHED;
                hold_open_next    = 1'b0;
                hold_elapsed_next = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold_mv <= THRESH_RESET;
      hold_ticks       <= HOLD_RESET;
      scan_divider     <= SCAN_RESET;
      confirm_count    <= CONFIRM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HOT_THRESHOLD: hot_threshold_mv <= cfg_data[THRESH_W-1:0];
        CFG_HOLD_TICKS:    hold_ticks       <= cfg_data[HOLD_W-1:0];
        CFG_SCAN_DIVIDER:  scan_divider     <= cfg_data[SCAN_W-1:0];
        CFG_CONFIRM_COUNT: confirm_count    <= cfg_data[CONFIRM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state_code     <= ST_NORMAL;
      prescale_count <= '0;
      normal_confirm <= '0;
      hot_confirm    <= '0;
      hold_open      <= 1'b0;
      hold_elapsed   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        state_code     <= state_code_next;
        prescale_count <= prescale_count_next;
        normal_confirm <= normal_confirm_next;
        hot_confirm    <= hot_confirm_next;
        hold_open      <= hold_open_next;
        hold_elapsed   <= hold_elapsed_next;
        temp_state     <= state_code_next;
        timer_running  <= hold_open_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* bench/tb.sv */
// tb: self-checking bench for the over-temperature supervisor, scan, hot hold and latch
// depends on otds_pkg and overtemp_derate_supervisor_top

module tb;
  import otds_pkg::*;

  localparam int unsigned MV_NUM = 12;
  localparam int unsigned MV_DEN = 10;

  // tracked supervisor state
  typedef struct packed {
    temp_state_t          st;
    logic [SCAN_W-1:0]    prescale;
    logic [CONFIRM_W-1:0] normal_run;
    logic [CONFIRM_W-1:0] hot_run;
    logic                 timer_open;
    logic [HOLD_W-1:0]    elapsed;
  } sup_t;

  typedef struct packed {
    temp_state_t st;
    logic        running;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = 1'b0;
  logic [ADC_W-1:0]      temp_adc = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATE_W-1:0]    temp_state;
  logic                  timer_running;

  // register copies and supervisor state as seen by the predictor
  logic [THRESH_W-1:0]  thresh_mv    = THRESH_RESET;
  logic [HOLD_W-1:0]    hold_limit   = HOLD_RESET;
  logic [SCAN_W-1:0]    scan_div     = SCAN_RESET;
  logic [CONFIRM_W-1:0] confirm_need = CONFIRM_RESET;
  sup_t                 tracked = '0;

  status_t expected_status[$];
  int      failures = 0;
  bit      idle_bursts = 1'b1;
  int      stall_left = 0;

  overtemp_derate_supervisor_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .temp_adc      (temp_adc),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .temp_state    (temp_state),
    .timer_running (timer_running)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // saturating run of low readings, cleared by a high one
  function automatic logic [CONFIRM_W-1:0] extend_low_run(
    input logic [CONFIRM_W-1:0] run,
    input logic                 low
  );
    if (!low) return '0;
    return (run == CONFIRM_MAX) ? run : run + CONFIRM_W'(1);
  endfunction

  // supervisor state after one word
  function automatic sup_t next_supervisor(input sup_t s, input logic k,
                                           input logic [ADC_W-1:0] adc);
    logic [SCAN_W-1:0] nxt;
    int unsigned       mv;
    logic              low;
    if (k == KIND_TICK) begin
      if (s.timer_open && s.elapsed != HOLD_MAX) s.elapsed = s.elapsed + 32'd1;
    end else if (s.st != ST_LATCHED) begin
      nxt = s.prescale + SCAN_W'(1);
      if (nxt < scan_div) begin
        s.prescale = nxt;
      end else begin
        s.prescale = '0;
        mv  = 32'(adc) * MV_NUM / MV_DEN;
        low = mv < 32'(thresh_mv);
        case (s.st)
          ST_NORMAL: begin
            s.normal_run = extend_low_run(s.normal_run, low);
            if (s.normal_run >= confirm_need) begin
              s.normal_run = '0;
              s.st = ST_HOT;
            end
          end
          ST_HOT: begin
            if (!s.timer_open) begin
              s.timer_open = 1'b1;
              s.elapsed = '0;
            end
            if (s.elapsed >= hold_limit) begin
              s.hot_run = extend_low_run(s.hot_run, low);
              if (s.hot_run >= confirm_need) begin
                s.hot_run = '0;
                s.st = ST_LATCHED;
                s.timer_open = 1'b0;
                s.elapsed = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
    return s;
  endfunction

  // reading biased toward the current threshold
  function automatic logic [ADC_W-1:0] pick_adc();
    int center;
    int v;
    center = int'(thresh_mv) * MV_DEN / MV_NUM;
    if (center > 4095) center = 4095;
    case ($urandom_range(0, 3))
      0:       v = center + int'($urandom_range(0, 6)) - 3;
      1:       v = int'($urandom_range(0, center));
      2:       v = $urandom_range(0, 1) ? 4095 : 0;
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return ADC_W'(v);
  endfunction

  // send one word and record its expected status
  task automatic send_word(input logic k, input logic [ADC_W-1:0] adc);
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    temp_adc <= adc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracked = next_supervisor(tracked, k, adc);
    expected_status.push_back('{st: tracked.st, running: tracked.timer_open});
  endtask

  // same, but never lets the word move the state forward
  task automatic send_steady(input logic k, input logic [ADC_W-1:0] adc);
    logic             kk;
    logic [ADC_W-1:0] aa;
    sup_t             probe;
    kk = k;
    aa = adc;
    if (kk == KIND_SAMPLE) begin
      probe = next_supervisor(tracked, kk, aa);
      if (probe.st != tracked.st) begin
        aa = '1;
        probe = next_supervisor(tracked, kk, aa);
        if (probe.st != tracked.st) kk = KIND_TICK;
      end
    end
    send_word(kk, aa);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HOT_THRESHOLD: thresh_mv    = value[THRESH_W-1:0];
      CFG_HOLD_TICKS:    hold_limit   = value[HOLD_W-1:0];
      CFG_SCAN_DIVIDER:  scan_div     = value[SCAN_W-1:0];
      CFG_CONFIRM_COUNT: confirm_need = value[CONFIRM_W-1:0];
      default: ;
    endcase
  endtask

  // write all registers once the block is idle; unused upper bits carry junk
  task automatic set_config(input logic [THRESH_W-1:0] thr, input logic [HOLD_W-1:0] hold,
                            input logic [SCAN_W-1:0] div, input logic [CONFIRM_W-1:0] conf);
    logic [CFG_DATA_W-1:0] d;
    drain_results();
    d = $urandom;
    d[THRESH_W-1:0] = thr;
    write_reg(CFG_HOT_THRESHOLD, d);
    write_reg(CFG_HOLD_TICKS, hold);
    d = $urandom;
    d[SCAN_W-1:0] = div;
    write_reg(CFG_SCAN_DIVIDER, d);
    d = $urandom;
    d[CONFIRM_W-1:0] = conf;
    write_reg(CFG_CONFIRM_COUNT, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SCAN_W-1:0] pick_divider();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return SCAN_W'(1);
      2:       return SCAN_W'($urandom_range(2, 4));
      3:       return SCAN_W'($urandom_range(5, 12));
      default: return ($urandom_range(0, 7) == 0) ? SCAN_W'(255) : SCAN_W'(3);
    endcase
  endfunction

  function automatic logic pick_kind(input int tick_pct);
    return ($urandom_range(0, 99) < tick_pct) ? KIND_TICK : KIND_SAMPLE;
  endfunction

  // register defaults: slow prescaler, closed timer
  task automatic t_reset_defaults();
    send_word(KIND_TICK, 12'h000);
    send_word(KIND_SAMPLE, 12'h000);
    send_word(KIND_SAMPLE, 12'hfff);
    send_word(KIND_TICK, 12'hfff);
  endtask

  // field extremes, threshold boundary and divider extremes in the normal state
  task automatic t_directed_extremes();
    set_config('0, HOLD_MAX, SCAN_W'(1), CONFIRM_W'(15));
    send_word(KIND_SAMPLE, 12'h000);
    send_word(KIND_SAMPLE, 12'hfff);
    send_word(KIND_SAMPLE, 12'haaa);
    send_word(KIND_SAMPLE, 12'h555);
    // 833 -> 999 mv is low, 834 -> 1000 mv is not
    set_config(THRESH_W'(1000), '0, '0, CONFIRM_W'(15));
    send_word(KIND_SAMPLE, 12'd833);
    send_word(KIND_SAMPLE, 12'd834);
    send_word(KIND_SAMPLE, 12'd833);
    send_word(KIND_SAMPLE, 12'd833);
    send_word(KIND_TICK, 12'd833);
    send_word(KIND_SAMPLE, 12'd0);
    // every reading is low but the divider keeps it from being evaluated
    set_config('1, HOLD_W'(1), SCAN_W'(255), CONFIRM_W'(2));
    send_word(KIND_SAMPLE, 12'hfff);
    send_word(KIND_SAMPLE, 12'h000);
    send_word(KIND_SAMPLE, 12'hfff);
  endtask

  // random scans that build and break low runs without leaving normal
  task automatic t_normal_scan();
    logic [THRESH_W-1:0] thr;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = THRESH_W'($urandom_range(4900, 4930));
        default: thr = THRESH_W'($urandom_range(0, 4914));
      endcase
      set_config(thr, $urandom, pick_divider(), CONFIRM_W'($urandom_range(1, 15)));
      idle_bursts = (ph % 3) != 2;
      for (int i = 0; i < 60; i++) begin
        if (ph == 5 && i == 30) drain_results();
        send_steady(pick_kind(20), pick_adc());
      end
    end
  endtask

  // zero confirm count forces hot, ticks ignored until the timer opens, zero hold
  task automatic t_enter_hot();
    idle_bursts = 1'b1;
    set_config(THRESH_W'(2000), HOLD_W'(3), '0, '0);
    send_word(KIND_SAMPLE, 12'hfff);
    send_word(KIND_TICK, 12'h000);
    set_config(THRESH_W'(2000), '0, '0, CONFIRM_W'(4));
    send_word(KIND_SAMPLE, 12'hfff);
    send_word(KIND_TICK, 12'h000);
    send_word(KIND_SAMPLE, 12'h000);
    send_word(KIND_TICK, 12'h000);
  endtask

  // hot with the hold window set at or past the timer each phase, and set to zero in one phase
  task automatic t_hot_hold();
    logic [HOLD_W-1:0] hold;
    for (int ph = 0; ph < 8; ph++) begin
      hold = (ph == 3) ? '0 : tracked.elapsed + HOLD_W'($urandom_range(0, 40));
      set_config(THRESH_W'($urandom_range(0, 5000)), hold, SCAN_W'($urandom_range(0, 3)),
                 CONFIRM_W'($urandom_range(1, 15)));
      idle_bursts = (ph % 4) != 1;
      for (int i = 0; i < 50; i++) send_steady(pick_kind(40), pick_adc());
    end
  endtask

  // latch, then every word is ignored
  task automatic t_latch_shutdown();
    set_config('1, tracked.elapsed, '0, CONFIRM_W'(3));
    idle_bursts = 1'b0;
    while (tracked.st != ST_LATCHED) send_word(KIND_SAMPLE, pick_adc());
    for (int i = 0; i < 30; i++) send_word(pick_kind(40), pick_adc());
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    status_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("unexpected result word: temp_state %0d timer_running %0b",
               temp_state, timer_running);
        failures++;
      end else begin
        want = expected_status.pop_front();
        if (temp_state !== want.st) begin
          $error("temp_state: expected %0d, actual %0d", want.st, temp_state);
          failures++;
        end
        if (timer_running !== want.running) begin
          $error("timer_running: expected %0b, actual %0b", want.running, timer_running);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    t_reset_defaults();
    t_directed_extremes();
    t_normal_scan();
    t_enter_hot();
    t_hot_hold();
    t_latch_shutdown();
    drain_results();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #600000;
    $display("simulation failed");
    $finish;
  end

endmodule
